### design/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define QAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define QAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### design/qau_pkg.sv
// Types and constants of the quadrilateral area unit.
`default_nettype none
package qau_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] side_a;
    logic [15:0] side_b;
    logic [15:0] side_c;
    logic [15:0] side_d;
    logic [15:0] angle;
  } in_req_t;

  typedef struct packed {
    logic [31:0] area_value;
    logic [1:0]  status;
  } out_res_t;

  localparam logic [1:0] MODE_PGRAM   = 2'd0;
  localparam logic [1:0] MODE_RHOMBUS = 2'd1;
  localparam logic [1:0] MODE_TRAP    = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_EQUAL = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  localparam int AREA_W     = 32;
  localparam int SINE_W     = 31;
  localparam int ROOT_SCALE = 32;
  localparam int CORDIC_W   = 34;
  localparam int ATAN_DEPTH = 24;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

  // arctan(2^-i) in 2^32-per-turn units
  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage
`default_nettype wire

### design/qau_cordic_cell.sv
// One rotation step of the sine CORDIC chain.
`default_nettype none
module qau_cordic_cell #(
  parameter int STEP = 0,
  parameter int TAGW = 32
) (
  input  wire logic                                   clk,
  input  wire logic signed [qau_pkg::CORDIC_W-1:0]    x_i,
  input  wire logic signed [qau_pkg::CORDIC_W-1:0]    y_i,
  input  wire logic signed [qau_pkg::CORDIC_W-1:0]    z_i,
  input  wire logic        [TAGW-1:0]                 tag_i,
  output logic signed      [qau_pkg::CORDIC_W-1:0]    x_o,
  output logic signed      [qau_pkg::CORDIC_W-1:0]    y_o,
  output logic signed      [qau_pkg::CORDIC_W-1:0]    z_o,
  output logic             [TAGW-1:0]                 tag_o
);

  localparam int CW = qau_pkg::CORDIC_W;

  logic signed [CW-1:0] dx, dy, at;
  logic signed [CW-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic        [TAGW-1:0] tag_r;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    at = signed'(CW'(qau_pkg::ATAN_TAB[STEP]));
    if (!z_i[CW-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - at;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + at;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    tag_r <= tag_i;
  end

  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign tag_o = tag_r;

endmodule
`default_nettype wire

### design/qau_sqrt_cell.sv
// One result bit of the digit-by-digit square root chain.
`default_nettype none
module qau_sqrt_cell #(
  parameter int NW   = 104,
  parameter int K    = 0,
  parameter int TAGW = 32
) (
  input  wire logic [NW-1:0]   rad_i,
  input  wire logic [NW/2+1:0] rem_i,
  input  wire logic [NW/2-1:0] root_i,
  input  wire logic [TAGW-1:0] tag_i,
  input  wire logic            clk,
  output logic      [NW-1:0]   rad_o,
  output logic      [NW/2+1:0] rem_o,
  output logic      [NW/2-1:0] root_o,
  output logic      [TAGW-1:0] tag_o
);

  localparam int RW  = NW / 2;
  localparam int RMW = RW + 2;

  logic [RMW-1:0]  rem2, trial, rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [NW-1:0]   rad_r;
  logic [TAGW-1:0] tag_r;
  logic            ge;

  always_comb begin
    // remainder stays below 2^(K+1), so its top two bits are free here
    rem2     = {rem_i[RMW-3:0], rad_i[NW-1-2*K -: 2]};
    trial    = {root_i, 2'b01};
    ge       = rem2 >= trial;
    rem_nxt  = ge ? rem2 - trial : rem2;
    root_nxt = {root_i[RW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_i;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    tag_r  <= tag_i;
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign tag_o  = tag_r;

endmodule
`default_nettype wire

### design/qau_div_cell.sv
// One quotient bit of the restoring divider chain.
`default_nettype none
module qau_div_cell #(
  parameter int DW   = 16,
  parameter int K    = 0,
  parameter int TAGW = 1
) (
  input  wire logic                          clk,
  input  wire logic [qau_pkg::AREA_W-1:0]    dvd_i,
  input  wire logic [DW-1:0]                 dvs_i,
  input  wire logic [DW-1:0]                 rem_i,
  input  wire logic [qau_pkg::AREA_W-1:0]    quo_i,
  input  wire logic [TAGW-1:0]               tag_i,
  output logic      [qau_pkg::AREA_W-1:0]    dvd_o,
  output logic      [DW-1:0]                 dvs_o,
  output logic      [DW-1:0]                 rem_o,
  output logic      [qau_pkg::AREA_W-1:0]    quo_o,
  output logic      [TAGW-1:0]               tag_o
);

  localparam int QW = qau_pkg::AREA_W;

  logic [DW:0]     rem2, diff;
  logic            ge;
  logic [DW-1:0]   rem_r, rem_nxt, dvs_r;
  logic [QW-1:0]   quo_r, quo_nxt, dvd_r;
  logic [TAGW-1:0] tag_r;

  always_comb begin
    rem2    = {rem_i, dvd_i[QW-1-K]};
    diff    = rem2 - {1'b0, dvs_i};
    ge      = rem2 >= {1'b0, dvs_i};
    rem_nxt = ge ? diff[DW-1:0] : rem2[DW-1:0];
    quo_nxt = {quo_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_i;
    dvs_r <= dvs_i;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    tag_r <= tag_i;
  end

  assign dvd_o = dvd_r;
  assign dvs_o = dvs_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign tag_o = tag_r;

endmodule
`default_nettype wire

### design/quadrilateral_area_unit.sv
// Trapezoids pass the square root chain (one cell per root bit) and the 32-cell divider chain.
// Throughput: one request per cycle unless busy; busy is high in reset and the first cycle after.
// Results come out in request order; the receiver cannot stall them.
// Reset (rst_n low, synchronous) clears all valid flags; the data chains are not reset.
`default_nettype none
module quadrilateral_area_unit #(
  parameter int SIDE_WIDTH   = 16,
  parameter int FRAC_BITS    = 8,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire qau_pkg::in_req_t in_req,
  output logic                  out_valid,
  output qau_pkg::out_res_t     out_res
);

  localparam int SW    = SIDE_WIDTH;
  localparam int CW    = qau_pkg::CORDIC_W;
  localparam int QW    = qau_pkg::AREA_W;
  localparam int SNW   = qau_pkg::SINE_W;
  localparam int GW    = SW + 2;
  localparam int PW4   = 4 * GW;
  localparam int NW    = PW4 + qau_pkg::ROOT_SCALE;
  localparam int RW    = NW / 2;
  localparam int RMW   = RW + 2;
  localparam int ACW   = SW + 1;
  localparam int TGW   = ACW + SW;
  localparam int NUMW  = ACW + RW;
  localparam int TSH   = 2 * FRAC_BITS + 2;
  localparam int PSH   = 2 * FRAC_BITS + 14;
  localparam int ABW   = 2 * SW;
  localparam int PRW   = ABW + SNW;
  localparam int CL    = RW + 38;
  localparam int PGL   = RW + 36 - CORDIC_STEPS;

  typedef struct packed {
    logic       valid;
    logic       is_trap;
    logic       pre_fail;
    logic [1:0] pre_code;
  } ctl_t;

  // ---------------- request register
  logic             busy_r, s0_valid_r, accept;
  qau_pkg::in_req_t s0_r;

  assign accept = start & ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      s0_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      s0_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= in_req;
  end

  // ---------------- decode
  logic [SW-1:0]          am, bm, cm, dm, b_eff, xd;
  logic signed [GW:0]     xs, bs, ds, g1, g2, g3, g4;
  logic [ACW-1:0]         ac;
  logic                   zero_ab, zero4, nonpos;
  logic [ANGLE_WIDTH-1:0] ang_m;
  logic [31:0]            t32, tw, zf;
  logic                   pre_fail;
  logic [1:0]             pre_code;

  always_comb begin
    am      = SW'(s0_r.side_a);
    bm      = SW'(s0_r.side_b);
    cm      = SW'(s0_r.side_c);
    dm      = SW'(s0_r.side_d);
    b_eff   = (s0_r.mode == qau_pkg::MODE_RHOMBUS) ? am : bm;
    zero_ab = (am == '0) || (b_eff == '0);
    zero4   = (am == '0) || (bm == '0) || (cm == '0) || (dm == '0);
    xd      = (am >= cm) ? am - cm : cm - am;
    xs      = signed'((GW + 1)'(xd));
    bs      = signed'((GW + 1)'(bm));
    ds      = signed'((GW + 1)'(dm));
    g1      = xs + bs + ds;
    g2      = bs + ds - xs;
    g3      = xs + ds - bs;
    g4      = xs + bs - ds;
    nonpos  = (g2 <= 0) || (g3 <= 0) || (g4 <= 0);
    ac      = ACW'(am) + ACW'(cm);

    // fold the angle into [0, quarter turn]; |sin| repeats every half turn
    ang_m = ANGLE_WIDTH'(s0_r.angle);
    t32   = {ang_m, {(32 - ANGLE_WIDTH){1'b0}}};
    tw    = {1'b0, t32[30:0]};
    zf    = (tw > qau_pkg::QUARTER_TURN) ? qau_pkg::HALF_TURN - tw : tw;

    pre_fail = 1'b1;
    pre_code = qau_pkg::ST_NONE;
    case (s0_r.mode)
      qau_pkg::MODE_PGRAM, qau_pkg::MODE_RHOMBUS: begin
        pre_fail = zero_ab;
      end
      qau_pkg::MODE_TRAP: begin
        if (zero4) begin
          pre_fail = 1'b1;
        end else if (am == cm) begin
          pre_code = qau_pkg::ST_EQUAL;
        end else if (nonpos) begin
          pre_fail = 1'b1;
        end else begin
          pre_fail = 1'b0;
        end
      end
      default: begin
        pre_fail = 1'b1;
      end
    endcase
  end

  // ---------------- control line
  ctl_t ctl_r [CL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CL; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      ctl_r[0] <= '{valid: s0_valid_r, is_trap: (s0_r.mode == qau_pkg::MODE_TRAP),
                    pre_fail: pre_fail, pre_code: pre_code};
      for (int i = 1; i < CL; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  // ---------------- parallelogram / rhombus: sine chain
  logic signed [CW-1:0] z0_r;
  logic [ABW-1:0]       ab0_r;

  always_ff @(posedge clk) begin
    z0_r  <= signed'(CW'(zf));
    ab0_r <= ABW'(am) * ABW'(b_eff);
  end

  logic signed [CW-1:0] cx_w [CORDIC_STEPS+1];
  logic signed [CW-1:0] cy_w [CORDIC_STEPS+1];
  logic signed [CW-1:0] cz_w [CORDIC_STEPS+1];
  logic [ABW-1:0]       cab_w [CORDIC_STEPS+1];

  assign cx_w[0]  = qau_pkg::CORDIC_GAIN;
  assign cy_w[0]  = '0;
  assign cz_w[0]  = z0_r;
  assign cab_w[0] = ab0_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    qau_cordic_cell #(.STEP(i), .TAGW(ABW)) u_cell (
      .clk   (clk),
      .x_i   (cx_w[i]),
      .y_i   (cy_w[i]),
      .z_i   (cz_w[i]),
      .tag_i (cab_w[i]),
      .x_o   (cx_w[i+1]),
      .y_o   (cy_w[i+1]),
      .z_o   (cz_w[i+1]),
      .tag_o (cab_w[i+1])
    );
  end

  logic [SNW-1:0]  sine;
  logic [PRW-1:0]  prod_r;
  logic [PRW+32:0] pqx;
  logic [QW:0]     pgd_r [PGL];

  always_comb begin
    if (cy_w[CORDIC_STEPS][CW-1]) begin
      sine = '0;
    end else if (cy_w[CORDIC_STEPS] > signed'(CW'(qau_pkg::QUARTER_TURN))) begin
      sine = SNW'(qau_pkg::QUARTER_TURN);
    end else begin
      sine = cy_w[CORDIC_STEPS][SNW-1:0];
    end
    pqx = (PRW + 33)'(prod_r) >> PSH;
  end

  always_ff @(posedge clk) begin
    prod_r   <= PRW'(cab_w[CORDIC_STEPS]) * PRW'(sine);
    pgd_r[0] <= {|pqx[PRW+32:QW], pqx[QW-1:0]};
    for (int i = 1; i < PGL; i++) begin
      pgd_r[i] <= pgd_r[i-1];
    end
  end

  // ---------------- trapezoid: radicand product
  logic [GW-1:0]    g1_r, g2_r, g3_r, g4_r;
  logic [2*GW-1:0]  p12_r, p34_r;
  logic [3*GW-1:0]  mlo_r, mhi_r;
  logic [PW4-1:0]   pr_r;
  logic [TGW-1:0]   acx_r [4];

  always_ff @(posedge clk) begin
    g1_r     <= g1[GW-1:0];
    g2_r     <= g2[GW-1:0];
    g3_r     <= g3[GW-1:0];
    g4_r     <= g4[GW-1:0];
    acx_r[0] <= {ac, xd};
    for (int i = 1; i < 4; i++) begin
      acx_r[i] <= acx_r[i-1];
    end
    p12_r <= (2 * GW)'(g1_r) * (2 * GW)'(g2_r);
    p34_r <= (2 * GW)'(g3_r) * (2 * GW)'(g4_r);
    mlo_r <= (3 * GW)'(p12_r) * (3 * GW)'(p34_r[GW-1:0]);
    mhi_r <= (3 * GW)'(p12_r) * (3 * GW)'(p34_r[2*GW-1:GW]);
    pr_r  <= PW4'(mlo_r) + (PW4'(mhi_r) << GW);
  end

  // ---------------- trapezoid: square root chain
  logic [NW-1:0]  rad_w  [RW+1];
  logic [RMW-1:0] rem_w  [RW+1];
  logic [RW-1:0]  root_w [RW+1];
  logic [TGW-1:0] stag_w [RW+1];

  assign rad_w[0]  = {pr_r, {qau_pkg::ROOT_SCALE{1'b0}}};
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign stag_w[0] = acx_r[3];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    qau_sqrt_cell #(.NW(NW), .K(k), .TAGW(TGW)) u_cell (
      .rad_i  (rad_w[k]),
      .rem_i  (rem_w[k]),
      .root_i (root_w[k]),
      .tag_i  (stag_w[k]),
      .clk    (clk),
      .rad_o  (rad_w[k+1]),
      .rem_o  (rem_w[k+1]),
      .root_o (root_w[k+1]),
      .tag_o  (stag_w[k+1])
    );
  end

  // ---------------- trapezoid: scale and divide
  logic [NUMW-1:0]  num_r;
  logic [SW-1:0]    xm_r;
  logic [NUMW+32:0] nqx;
  logic [NUMW:0]    nhi;
  logic [QW-1:0]    dvd0_r;
  logic [SW-1:0]    dvs0_r, rem0_r;
  logic             dsat0_r;

  always_comb begin
    // x * 2^TSH divides num: drop the power of two first
    nqx = (NUMW + 33)'(num_r) >> TSH;
    nhi = nqx[NUMW+32:QW];
  end

  always_ff @(posedge clk) begin
    num_r   <= NUMW'(stag_w[RW][TGW-1:SW]) * NUMW'(root_w[RW]);
    xm_r    <= stag_w[RW][SW-1:0];
    dvd0_r  <= nqx[QW-1:0];
    dvs0_r  <= xm_r;
    rem0_r  <= nhi[SW-1:0];
    dsat0_r <= nhi >= (NUMW + 1)'(xm_r);
  end

  logic [QW-1:0] dvd_w [QW+1];
  logic [SW-1:0] dvs_w [QW+1];
  logic [SW-1:0] drm_w [QW+1];
  logic [QW-1:0] quo_w [QW+1];
  logic          dst_w [QW+1];

  assign dvd_w[0] = dvd0_r;
  assign dvs_w[0] = dvs0_r;
  assign drm_w[0] = rem0_r;
  assign quo_w[0] = '0;
  assign dst_w[0] = dsat0_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    qau_div_cell #(.DW(SW), .K(k), .TAGW(1)) u_cell (
      .clk   (clk),
      .dvd_i (dvd_w[k]),
      .dvs_i (dvs_w[k]),
      .rem_i (drm_w[k]),
      .quo_i (quo_w[k]),
      .tag_i (dst_w[k]),
      .dvd_o (dvd_w[k+1]),
      .dvs_o (dvs_w[k+1]),
      .rem_o (drm_w[k+1]),
      .quo_o (quo_w[k+1]),
      .tag_o (dst_w[k+1])
    );
  end

  // ---------------- result
  ctl_t              fin;
  logic              fsat;
  logic [QW-1:0]     fq;
  logic              out_valid_r;
  qau_pkg::out_res_t out_res_r, out_res_nxt;

  always_comb begin
    fin  = ctl_r[CL-1];
    fsat = fin.is_trap ? dst_w[QW] : pgd_r[PGL-1][QW];
    fq   = fin.is_trap ? quo_w[QW] : pgd_r[PGL-1][QW-1:0];
    if (fin.pre_fail) begin
      out_res_nxt.status = fin.pre_code;
    end else if (fsat) begin
      out_res_nxt.status = qau_pkg::ST_SAT;
    end else if (fq == '0) begin
      out_res_nxt.status = qau_pkg::ST_NONE;
    end else begin
      out_res_nxt.status = qau_pkg::ST_OK;
    end
    out_res_nxt.area_value = (out_res_nxt.status == qau_pkg::ST_OK) ? fq : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

### design/qau_checker.sv
// Port-level checker for the quadrilateral area unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module qau_checker #(
  parameter int SIDE_WIDTH = 16
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire qau_pkg::in_req_t  in_req,
  input wire logic              out_valid,
  input wire qau_pkg::out_res_t out_res
);

  localparam int LAT = 2 * SIDE_WIDTH + 60;

  logic req_acc, nofig_acc, status_ok, area_nz, status_none;

  assign req_acc     = start && !busy;
  assign nofig_acc   = req_acc && ((in_req.mode == qau_pkg::MODE_NONE) ||
                       ((in_req.mode == qau_pkg::MODE_RHOMBUS) && (in_req.side_a == 16'd0)));
  assign status_ok   = (out_res.status == qau_pkg::ST_OK);
  assign status_none = (out_res.status == qau_pkg::ST_NONE);
  assign area_nz     = (out_res.area_value != 32'd0);

  // busy drops in the cycle after reset is released and stays low
  `QAU_ASSERT_NXT(a_busy_low, clk, rst_n, rst_n, !busy)

  `QAU_ASSERT_IMP(a_out_has_req, clk, rst_n, out_valid, $past(req_acc, LAT))

  `QAU_ASSERT_IMP(a_area_vs_status, clk, rst_n, out_valid, status_ok == area_nz)

  `QAU_ASSERT_IMP(a_no_figure, clk, rst_n, out_valid && $past(nofig_acc, LAT), status_none)

endmodule

bind quadrilateral_area_unit qau_checker #(.SIDE_WIDTH(SIDE_WIDTH)) u_qau_checker (.*);
`default_nettype wire

### sim/area_checker.sv
// Checker for the quadrilateral area unit: predicts each area and compares results in order.
`timescale 1ns / 100ps
`default_nettype none
module area_checker (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire qau_pkg::in_req_t in_req,
  input  wire logic             out_valid,
  input  wire qau_pkg::out_res_t out_res,
  output int                    mismatches,
  output int                    pending
);

  qau_pkg::out_res_t area_queue[$];

  function automatic logic [31:0] abs_sine(input logic [15:0] ang);
    logic [31:0] t;
    longint x, y, z, dx, dy;
    t = {1'b0, ang[14:0], 16'h0};
    if (t > qau_pkg::QUARTER_TURN) t = qau_pkg::HALF_TURN - t;
    x = qau_pkg::CORDIC_GAIN;
    y = 0;
    z = longint'(t);
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(qau_pkg::ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(qau_pkg::ATAN_TAB[i]);
      end
    end
    if (y < 0) y = 0;
    if (y > longint'(qau_pkg::QUARTER_TURN)) y = longint'(qau_pkg::QUARTER_TURN);
    return y[31:0];
  endfunction

  function automatic logic [127:0] isqrt(input logic [127:0] n);
    logic [127:0] r, cand;
    r = '0;
    for (int i = 59; i >= 0; i--) begin
      cand = r | (128'd1 << i);
      if (cand * cand <= n) r = cand;
    end
    return r;
  endfunction

  function automatic qau_pkg::out_res_t predict_area(input qau_pkg::in_req_t q);
    qau_pkg::out_res_t res;
    logic [127:0] num, den, quo, p, root;
    longint a, b, c, d, x, g1, g2, g3, g4;
    a = q.side_a; b = q.side_b; c = q.side_c; d = q.side_d;
    res.status = qau_pkg::ST_NONE;
    res.area_value = '0;
    if (q.mode == qau_pkg::MODE_PGRAM || q.mode == qau_pkg::MODE_RHOMBUS) begin
      if (q.mode == qau_pkg::MODE_RHOMBUS) b = a;
      if (a != 0 && b != 0) begin
        num = 128'(a * b) * 128'(abs_sine(q.angle));
        quo = num >> 30;
        if (quo >= 128'h1_0000_0000) res.status = qau_pkg::ST_SAT;
        else begin
          res.status = qau_pkg::ST_OK;
          res.area_value = quo[31:0];
        end
      end
    end else if (q.mode == qau_pkg::MODE_TRAP) begin
      if (a != 0 && b != 0 && c != 0 && d != 0) begin
        if (a == c) res.status = qau_pkg::ST_EQUAL;
        else begin
          x = (a > c) ? a - c : c - a;
          g1 = x + b + d;
          g2 = b + d - x;
          g3 = x + d - b;
          g4 = x + b - d;
          if (g2 > 0 && g3 > 0 && g4 > 0) begin
            p = 128'(g1) * 128'(g2) * 128'(g3) * 128'(g4);
            root = isqrt(p << 32);
            num = 128'(a + c) * root;
            den = 128'(x) << 18;
            quo = num / den;
            if (quo >= 128'h1_0000_0000) res.status = qau_pkg::ST_SAT;
            else begin
              res.status = qau_pkg::ST_OK;
              res.area_value = quo[31:0];
            end
          end
        end
      end
    end
    if (res.status == qau_pkg::ST_OK && res.area_value == 0) res.status = qau_pkg::ST_NONE;
    if (res.status != qau_pkg::ST_OK) res.area_value = '0;
    return res;
  endfunction

  assign pending = area_queue.size();

  always @(posedge clk) begin
    qau_pkg::out_res_t want;
    if (!rst_n) begin
      area_queue.delete();
      mismatches <= 0;
    end else begin
      if (start && !busy) area_queue.push_back(predict_area(in_req));
      if (out_valid) begin
        if (area_queue.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: area %h status %0d",
                                        out_res.area_value, out_res.status);
          mismatches <= mismatches + 1;
        end else begin
          want = area_queue.pop_front();
          if (want.area_value !== out_res.area_value || want.status !== out_res.status) begin
            if (mismatches < 10)
              $display("mismatch: expected area %h status %0d, got area %h status %0d",
                       want.area_value, want.status, out_res.area_value, out_res.status);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### sim/tb.sv
// Testbench top: drives requests into the area unit and reports the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int LATENCY = 91;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [15:0] Z16 = 16'h0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy, out_valid;
  qau_pkg::in_req_t in_req = '0;
  qau_pkg::out_res_t out_res;
  int mismatches, pending;
  int cycles = 0;
  bit idle_ok = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  quadrilateral_area_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  area_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Holds the request until it is taken; the start level is decided one NBA per edge.
  task automatic send(input qau_pkg::in_req_t q);
    bit taken;
    start <= 1'b1;
    in_req <= q;
    forever begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
      if (taken) break;
    end
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      in_req <= qau_pkg::in_req_t'({$urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic [1:0] m, input logic [15:0] a, b, c, d, ang);
    qau_pkg::in_req_t q;
    q.mode = m; q.side_a = a; q.side_b = b; q.side_c = c; q.side_d = d; q.angle = ang;
    send(q);
  endtask

  function automatic logic [15:0] rand_side();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 16));
      1: return 16'($urandom_range(1, 1023));
      default: return 16'($urandom);
    endcase
  endfunction

  // Trapezoid: base difference strictly between |b-d| and b+d where the 65534 cap allows.
  task automatic send_trapezoid();
    int b, d, lo, hi, x, c;
    b = rand_side();
    d = rand_side();
    if (b == 0) b = 1;
    if (d == 0) d = 1;
    lo = (b > d ? b - d : d - b) + 1;
    hi = b + d - 1;
    if (hi > 65534) hi = 65534;
    if (lo > hi) lo = hi;
    x = $urandom_range(lo, hi);
    c = $urandom_range(1, 65535 - x);
    if ($urandom_range(0, 1))
      send_fields(qau_pkg::MODE_TRAP, 16'(c + x), 16'(b), 16'(c), 16'(d), 16'($urandom));
    else
      send_fields(qau_pkg::MODE_TRAP, 16'(c), 16'(b), 16'(c + x), 16'(d), 16'($urandom));
  endtask

  initial begin
    qau_pkg::in_req_t q;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_fields(qau_pkg::MODE_PGRAM, 16'hFFFF, 16'hFFFF, Z16, Z16, 16'h4000);
    send_fields(qau_pkg::MODE_PGRAM, 16'hFFFF, 16'hFFFF, Z16, Z16, 16'hC000);
    send_fields(qau_pkg::MODE_PGRAM, 16'h0100, 16'h0200, Z16, Z16, 16'h0000);
    send_fields(qau_pkg::MODE_PGRAM, 16'h0100, 16'h0200, Z16, Z16, 16'h8000);
    send_fields(qau_pkg::MODE_PGRAM, 16'h0000, 16'h0200, Z16, Z16, 16'h2000);
    send_fields(qau_pkg::MODE_PGRAM, 16'h0200, 16'h0000, Z16, Z16, 16'h2000);
    send_fields(qau_pkg::MODE_PGRAM, 16'h0001, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001);
    send_fields(qau_pkg::MODE_PGRAM, 16'h1234, 16'h4321, Z16, Z16, 16'hFFFF);
    send_fields(qau_pkg::MODE_RHOMBUS, 16'hFFFF, 16'h0000, Z16, Z16, 16'h4000);
    send_fields(qau_pkg::MODE_RHOMBUS, 16'h0000, 16'hFFFF, Z16, Z16, 16'h4000);
    send_fields(qau_pkg::MODE_RHOMBUS, 16'h0300, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h3FFF);
    send_fields(qau_pkg::MODE_TRAP, 16'h0A00, 16'h0500, 16'h0400, 16'h0500, Z16);
    send_fields(qau_pkg::MODE_TRAP, 16'h0400, 16'h0500, 16'h0A00, 16'h0500, Z16);
    send_fields(qau_pkg::MODE_TRAP, 16'h0500, 16'h0300, 16'h0500, 16'h0300, Z16);
    send_fields(qau_pkg::MODE_TRAP, 16'h0A00, 16'h0100, 16'h0400, 16'h0100, Z16);
    send_fields(qau_pkg::MODE_TRAP, 16'h0A00, 16'h0900, 16'h0400, 16'h0100, Z16);
    send_fields(qau_pkg::MODE_TRAP, 16'h0000, 16'h0500, 16'h0400, 16'h0500, Z16);
    send_fields(qau_pkg::MODE_TRAP, 16'h0A00, 16'h0500, 16'h0400, 16'h0000, Z16);
    send_fields(qau_pkg::MODE_TRAP, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF, Z16);
    send_fields(qau_pkg::MODE_TRAP, 16'hFFFF, 16'hFFFF, 16'hFFFD, 16'hFFFF, Z16);
    send_fields(qau_pkg::MODE_TRAP, 16'h0003, 16'h0001, 16'h0001, 16'h0001, Z16);
    send_fields(qau_pkg::MODE_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_fields(qau_pkg::MODE_NONE, Z16, Z16, Z16, Z16, Z16);

    // let the pipeline drain completely once
    start <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < 1030; n++) begin
      if (n > 900) idle_ok = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_trapezoid();
        4, 5: send_fields(qau_pkg::MODE_PGRAM, rand_side(), rand_side(), 16'($urandom),
                          16'($urandom), 16'($urandom));
        6, 7: send_fields(qau_pkg::MODE_RHOMBUS, rand_side(), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
        default: begin
          q = qau_pkg::in_req_t'({$urandom, $urandom, $urandom});
          send(q);
        end
      endcase
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
